/* sv/edf_pkg.sv */
package edf_pkg;

  localparam int unsigned MaxTasks = 8;
  localparam int unsigned TimeBits = 16;
  localparam int unsigned IdxBits  = $clog2(MaxTasks);
  localparam int unsigned CntBits  = 4;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [IdxBits-1:0]  idx_t;

  typedef struct packed {
    time_t budget;
    time_t deadline;
    time_t period;
    time_t countdown;
    time_t left;
    time_t phase;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   idx;
    entry_t entry;
  } wr_req_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

endpackage

/* sv/edf_tick_scheduler_top.sv */
// channel   | dir | tdata (low bit up)                                   | tuser
// s_axis    | in  | task_index 3, exec_budget 16, rel_deadline 16,      | req_type
//           |     | period_len 16, zero pad to 56                        |
// m_axis    | out | run_task 3, zero pad to 8                            | idle
// cfg       | in  | tasks_in_use 4, write when cfg_we_i high             | -
// a load item: transfer, then done state, then result register
// a tick, n = tasks in use capped at eight (none: straight to done): one shared compare
// unit scans the entries one per cycle, then one update unit advances them one per cycle
// reset clears all entries (period one), tasks in use to one, no result pending
// a stalled result holds the block in its final state until taken
module edf_tick_scheduler_top
  import edf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,     // tasks_in_use
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,    // task_index, exec_budget, rel_deadline, period_len
  input  logic        s_axis_tuser,    // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // run_task
  output logic        m_axis_tuser     // idle
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ADV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CntBits-1:0] tasks_q;
  idx_t               idx_q, idx_d;
  idx_t               best_q, best_d;
  time_t              best_cd_q, best_cd_d;
  logic               found_q, found_d;
  logic               out_valid_q, out_valid_d;
  idx_t               out_task_q, out_task_d;
  logic               out_idle_q, out_idle_d;

  logic [CntBits-1:0] n_act;
  idx_t               n_last;
  logic               s_fire;
  entry_t             rd_entry;
  entry_t             upd;
  wr_req_t            wr_req;
  time_t              last_phase;
  logic               can_emit;

  assign n_act  = (tasks_q > CntBits'(MaxTasks)) ? CntBits'(MaxTasks) : tasks_q;
  assign n_last = idx_t'(n_act - CntBits'(1));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign can_emit      = !out_valid_q || m_axis_tready;

  edf_task_file u_file (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_entry_o (rd_entry),
    .wr_i       (wr_req)
  );

  // update of one entry at the end of a tick
  always_comb begin
    upd        = rd_entry;
    last_phase = rd_entry.period - time_t'(1);
    if (rd_entry.phase == last_phase) begin
      upd.countdown = rd_entry.deadline;
      upd.left      = rd_entry.budget;
      upd.phase     = '0;
    end else begin
      if (rd_entry.countdown != '0) begin
        upd.countdown = rd_entry.countdown - time_t'(1);
      end
      upd.phase = rd_entry.phase + time_t'(1);
      if (found_q && (best_q == idx_q)) begin
        upd.left = rd_entry.left - time_t'(1);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    best_d      = best_q;
    best_cd_d   = best_cd_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    out_task_d  = out_task_q;
    out_idle_d  = out_idle_q;
    wr_req      = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          idx_d   = '0;
          found_d = 1'b0;
          best_d  = '0;
          if (s_axis_tuser == REQ_LOAD) begin
            wr_req.en              = 1'b1;
            wr_req.idx             = s_axis_tdata[2:0];
            wr_req.entry.budget    = s_axis_tdata[18:3];
            wr_req.entry.deadline  = s_axis_tdata[34:19];
            wr_req.entry.period    = s_axis_tdata[50:35];
            wr_req.entry.left      = s_axis_tdata[18:3];
            wr_req.entry.countdown = s_axis_tdata[34:19];
            wr_req.entry.phase     = '0;
            state_d                = ST_DONE;
          end else if (n_act == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if ((rd_entry.left != '0) && (!found_q || (rd_entry.countdown < best_cd_q))) begin
          found_d   = 1'b1;
          best_d    = idx_q;
          best_cd_d = rd_entry.countdown;
        end
        if (idx_q == n_last) begin
          idx_d   = '0;
          state_d = ST_ADV;
        end else begin
          idx_d = idx_q + idx_t'(1);
        end
      end
      ST_ADV: begin
        wr_req.en    = 1'b1;
        wr_req.idx   = idx_q;
        wr_req.entry = upd;
        if (idx_q == n_last) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + idx_t'(1);
        end
      end
      ST_DONE: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_task_d  = found_q ? best_q : '0;
          out_idle_d  = !found_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tasks_q     <= CntBits'(1);
      idx_q       <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      best_q      <= best_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tasks_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_cd_q  <= best_cd_d;
    out_task_q <= out_task_d;
    out_idle_q <= out_idle_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_task_q};
  assign m_axis_tuser  = out_idle_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_ADV) |-> (idx_q <= n_last))
    else $error("entry counter beyond tasks in use");

  a_best_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && found_q) |-> (best_q < idx_q))
    else $error("chosen task not yet scanned");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0))
    else $error("idle result carries a task number");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q != ST_IDLE))
    else $error("accepted item did not start work");

endmodule

/* sv/edf_task_file.sv */
module edf_task_file
  import edf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  idx_t    rd_idx_i,
  output entry_t  rd_entry_o,
  input  wr_req_t wr_i
);

  entry_t tbl_q [MaxTasks];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < MaxTasks; i++) begin
        tbl_q[i] <= '{period: time_t'(1), default: '0};
      end
    end else if (wr_i.en) begin
      tbl_q[wr_i.idx] <= wr_i.entry;
    end
  end

  assign rd_entry_o = tbl_q[rd_idx_i];

endmodule
